### sv/sntp_pkg.sv
// ----------------------------------------------------------------------------
// SNTP time string parser package
// Shared constants, the parser phase type and the result record.
// ----------------------------------------------------------------------------
package sntp_pkg;

    // Longest weekday or month token before it is cut off.
    localparam int TOKEN_MAX_DEF = 15;

    // Length of the "+CIPSNTPTIME:" prefix.
    localparam int PREFIX_LEN = 13;
    localparam int PREFIX_PW  = 4;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef enum logic [7:0] {
        PH_SEARCH = 8'b0000_0001,
        PH_WEEK   = 8'b0000_0010,
        PH_GAP    = 8'b0000_0100,
        PH_MONTH  = 8'b0000_1000,
        PH_NWAIT  = 8'b0001_0000,
        PH_NDIG   = 8'b0010_0000,
        PH_DONE   = 8'b0100_0000,
        PH_FAIL   = 8'b1000_0000
    } phase_t;

    // Which of the five numbers is being parsed.
    typedef enum logic [2:0] {
        IDX_DAY  = 3'd0,
        IDX_HOUR = 3'd1,
        IDX_MIN  = 3'd2,
        IDX_SEC  = 3'd3,
        IDX_YEAR = 3'd4
    } num_idx_t;

    typedef struct packed {
        logic        ok;
        logic [15:0] year;
        logic [3:0]  month;
        logic [7:0]  day;
        logic [7:0]  hour;
        logic [7:0]  minute;
        logic [7:0]  second;
        logic [2:0]  weekday;
    } res_t;

    function automatic logic [7:0] prefix_char(input logic [PREFIX_PW-1:0] pos);
        logic [7:0] ch;
        case (pos)
            4'd0:    ch = 8'h2B; // '+'
            4'd1:    ch = 8'h43; // 'C'
            4'd2:    ch = 8'h49; // 'I'
            4'd3:    ch = 8'h50; // 'P'
            4'd4:    ch = 8'h53; // 'S'
            4'd5:    ch = 8'h4E; // 'N'
            4'd6:    ch = 8'h54; // 'T'
            4'd7:    ch = 8'h50; // 'P'
            4'd8:    ch = 8'h54; // 'T'
            4'd9:    ch = 8'h49; // 'I'
            4'd10:   ch = 8'h4D; // 'M'
            4'd11:   ch = 8'h45; // 'E'
            4'd12:   ch = 8'h3A; // ':'
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

### sv/sntp_time_string_parser_unit.sv
// ----------------------------------------------------------------------------
// SNTP time string parser
// Scans a modem response one character per item for "+CIPSNTPTIME:" and
// parses the asctime-style date and time that follows it.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel carries one character per item (s_char_byte) and s_last,
//   which marks the final character of a response. Only the item with
//   s_last set produces a result on the m_ channel; all other items just
//   advance the parser. A zero byte ends the text; later characters are
//   ignored until s_last.
//   Each item is parsed in the cycle it is accepted, so one item is taken
//   every cycle while s_ready is high. The result is registered and shows up
//   on m_valid in the cycle after the last item is taken if the output is free.
//   The output register is backed by a one-entry skid buffer: while a result
//   waits for m_ready, characters keep being accepted, and s_ready drops only
//   once a second result has been parked in the skid buffer.
//   On failure m_ok and all result fields are zero. After each result the
//   parser returns to its reset state. Reset (aresetn low, synchronous)
//   empties both output stages and restarts the prefix search.
// ----------------------------------------------------------------------------
module sntp_time_string_parser_unit
    import sntp_pkg::*;
#(
    parameter int TOKEN_MAX = TOKEN_MAX_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_byte,
    input  logic        s_last,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_ok,
    output logic [15:0] m_year,
    output logic [3:0]  m_month,
    output logic [7:0]  m_day,
    output logic [7:0]  m_hour,
    output logic [7:0]  m_minute,
    output logic [7:0]  m_second,
    output logic [2:0]  m_weekday
);

    localparam int TLW = $clog2(TOKEN_MAX + 1);

    typedef struct packed {
        phase_t               phase;
        logic [PREFIX_PW-1:0] prefix_pos;
        logic [TLW-1:0]       token_len;
        logic [15:0]          weekday_chars;
        logic [23:0]          month_chars;
        logic [15:0]          number_acc;
        logic                 digit_seen;
        logic                 negative;
        num_idx_t             num_idx;
        logic [7:0]           day_val;
        logic [7:0]           hour_val;
        logic [7:0]           minute_val;
        logic [7:0]           second_val;
    } pstate_t;

    localparam pstate_t PSTATE_RESET = '{
        phase:         PH_SEARCH,
        prefix_pos:    '0,
        token_len:     '0,
        weekday_chars: '0,
        month_chars:   '0,
        number_acc:    '0,
        digit_seen:    1'b0,
        negative:      1'b0,
        num_idx:       IDX_DAY,
        day_val:       '0,
        hour_val:      '0,
        minute_val:    '0,
        second_val:    '0
    };

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic pstate_t start_number(input pstate_t s, input num_idx_t k);
        pstate_t r;
        r            = s;
        r.phase      = PH_NWAIT;
        r.num_idx    = k;
        r.number_acc = '0;
        r.digit_seen = 1'b0;
        r.negative   = 1'b0;
        return r;
    endfunction

    // Before the first digit: skip whitespace, take one sign or a digit.
    function automatic pstate_t num_wait(input pstate_t s, input logic [7:0] c);
        pstate_t r;
        r = s;
        if (is_ws(c)) begin
            r = s;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
            r.negative = (c == CH_MINUS);
            r.phase    = PH_NDIG;
        end else if (is_digit(c)) begin
            r.number_acc = {8'd0, c - CH_ZERO};
            r.digit_seen = 1'b1;
            r.phase      = PH_NDIG;
        end else begin
            r.phase = PH_FAIL;
        end
        return r;
    endfunction

    function automatic logic [15:0] signed_val(input pstate_t s);
        return s.negative ? (16'd0 - s.number_acc) : s.number_acc;
    endfunction

    // One character of text, not the end of text.
    function automatic pstate_t feed_char(input pstate_t s, input logic [7:0] c);
        pstate_t              r;
        logic [TLW-1:0]       tl_inc;
        logic [PREFIX_PW-1:0] pos_inc;
        logic [15:0]          v;
        r       = s;
        tl_inc  = s.token_len + 1'b1;
        pos_inc = s.prefix_pos + 1'b1;
        v       = signed_val(s);
        case (s.phase)
            PH_SEARCH: begin
                if (c == prefix_char(s.prefix_pos)) begin
                    r.prefix_pos = pos_inc;
                    if (pos_inc == PREFIX_PW'(PREFIX_LEN)) begin
                        r.phase         = PH_WEEK;
                        r.token_len     = '0;
                        r.weekday_chars = '0;
                    end
                end else begin
                    r.prefix_pos = (c == CH_PLUS) ? PREFIX_PW'(1) : '0;
                end
            end
            PH_WEEK: begin
                if (c == CH_SPACE) begin
                    r.phase = (s.token_len != '0) ? PH_GAP : PH_FAIL;
                end else begin
                    if (s.token_len == TLW'(0)) r.weekday_chars[7:0] = s.weekday_chars[7:0] | c;
                    if (s.token_len == TLW'(1)) r.weekday_chars[15:8] = s.weekday_chars[15:8] | c;
                    r.token_len = tl_inc;
                    if (tl_inc >= TLW'(TOKEN_MAX)) r.phase = PH_GAP;
                end
            end
            PH_GAP: begin
                // The first non-whitespace character is also the first month letter.
                if (!is_ws(c)) begin
                    r.month_chars = {16'd0, c};
                    r.token_len   = TLW'(1);
                    r.phase       = PH_MONTH;
                end
            end
            PH_MONTH: begin
                if (c == CH_SPACE) begin
                    if (s.token_len != '0) r = start_number(s, IDX_DAY);
                    else r.phase = PH_FAIL;
                end else begin
                    if (s.token_len == TLW'(0)) r.month_chars[7:0] = s.month_chars[7:0] | c;
                    if (s.token_len == TLW'(1)) r.month_chars[15:8] = s.month_chars[15:8] | c;
                    if (s.token_len == TLW'(2)) r.month_chars[23:16] = s.month_chars[23:16] | c;
                    r.token_len = tl_inc;
                    if (tl_inc >= TLW'(TOKEN_MAX)) r = start_number(r, IDX_DAY);
                end
            end
            PH_NWAIT: begin
                r = num_wait(s, c);
            end
            PH_NDIG: begin
                if (is_digit(c)) begin
                    r.number_acc = (s.number_acc << 3) + (s.number_acc << 1)
                                 + {8'd0, c - CH_ZERO};
                    r.digit_seen = 1'b1;
                end else if (!s.digit_seen) begin
                    r.phase = PH_FAIL;
                end else begin
                    case (s.num_idx)
                        IDX_DAY: begin
                            r.day_val = v[7:0];
                            r = num_wait(start_number(r, IDX_HOUR), c);
                        end
                        IDX_HOUR: begin
                            r.hour_val = v[7:0];
                            if (c == CH_COLON) r = start_number(r, IDX_MIN);
                            else r.phase = PH_FAIL;
                        end
                        IDX_MIN: begin
                            r.minute_val = v[7:0];
                            if (c == CH_COLON) r = start_number(r, IDX_SEC);
                            else r.phase = PH_FAIL;
                        end
                        IDX_SEC: begin
                            r.second_val = v[7:0];
                            r = num_wait(start_number(r, IDX_YEAR), c);
                        end
                        IDX_YEAR: begin
                            r.number_acc = v;
                            r.phase      = PH_DONE;
                        end
                        default: begin
                            r.phase = PH_FAIL;
                        end
                    endcase
                end
            end
            default: begin
                r = s;
            end
        endcase
        return r;
    endfunction

    // End of text: only a finished year, or one whose digits are still
    // running, survives; every other phase fails.
    function automatic pstate_t end_text(input pstate_t s);
        pstate_t r;
        r = s;
        if (s.phase == PH_DONE) begin
            r = s;
        end else if (s.phase == PH_NDIG && s.num_idx == IDX_YEAR && s.digit_seen) begin
            r.number_acc = signed_val(s);
            r.phase      = PH_DONE;
        end else begin
            r.phase = PH_FAIL;
        end
        return r;
    endfunction

    function automatic logic [3:0] month_code(input logic [23:0] m);
        logic [3:0] code;
        case (m[7:0])
            8'h4A:   code = (m[15:8] == 8'h61) ? 4'd1 : ((m[23:16] == 8'h6E) ? 4'd6 : 4'd7);
            8'h46:   code = 4'd2;
            8'h4D:   code = (m[23:16] == 8'h72) ? 4'd3 : 4'd5;
            8'h41:   code = (m[15:8] == 8'h70) ? 4'd4 : 4'd8;
            8'h53:   code = 4'd9;
            8'h4F:   code = 4'd10;
            8'h4E:   code = 4'd11;
            8'h44:   code = 4'd12;
            default: code = 4'd0;
        endcase
        return code;
    endfunction

    function automatic logic [2:0] weekday_code(input logic [15:0] w);
        logic [2:0] code;
        case (w[7:0])
            8'h4D:   code = 3'd1;
            8'h54:   code = (w[15:8] == 8'h75) ? 3'd2 : 3'd4;
            8'h57:   code = 3'd3;
            8'h46:   code = 3'd5;
            8'h53:   code = (w[15:8] == 8'h61) ? 3'd6 : 3'd7;
            default: code = 3'd0;
        endcase
        return code;
    endfunction

    pstate_t pst_reg, pst_next;
    logic    text_ended_reg, text_ended_next;
    pstate_t feed_st, eot_src, eot_st, post_st;
    res_t    res_new;
    res_t    out_reg, out_next, skid_reg, skid_next;
    logic    out_valid_reg, out_valid_next, skid_valid_reg, skid_valid_next;
    logic    s_take, res_push, m_take, is_nul;

    assign s_ready  = ~skid_valid_reg;
    assign s_take   = s_valid & s_ready;
    assign res_push = s_take & s_last;
    assign m_take   = out_valid_reg & m_ready;
    assign is_nul   = (s_char_byte == CH_NUL);

    always_comb begin
        feed_st = feed_char(pst_reg, s_char_byte);
        eot_src = (text_ended_reg || is_nul) ? pst_reg : feed_st;
        eot_st  = end_text(eot_src);
        if (text_ended_reg) post_st = pst_reg;
        else if (is_nul) post_st = eot_st;
        else post_st = feed_st;

        res_new = '0;
        if (eot_st.phase == PH_DONE) begin
            res_new.ok      = 1'b1;
            res_new.year    = eot_st.number_acc;
            res_new.month   = month_code(eot_st.month_chars);
            res_new.day     = eot_st.day_val;
            res_new.hour    = eot_st.hour_val;
            res_new.minute  = eot_st.minute_val;
            res_new.second  = eot_st.second_val;
            res_new.weekday = weekday_code(eot_st.weekday_chars);
        end

        pst_next        = pst_reg;
        text_ended_next = text_ended_reg;
        if (s_take) begin
            if (s_last) begin
                pst_next        = PSTATE_RESET;
                text_ended_next = 1'b0;
            end else begin
                pst_next        = post_st;
                text_ended_next = text_ended_reg | is_nul;
            end
        end
    end

    // Output register with a one-entry skid buffer behind it.
    always_comb begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || m_take) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                out_next       = res_new;
                out_valid_next = res_push;
            end
        end else if (res_push) begin
            skid_next       = res_new;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pst_reg        <= PSTATE_RESET;
            text_ended_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            pst_reg        <= pst_next;
            text_ended_reg <= text_ended_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_valid   = out_valid_reg;
    assign m_ok      = out_reg.ok;
    assign m_year    = out_reg.year;
    assign m_month   = out_reg.month;
    assign m_day     = out_reg.day;
    assign m_hour    = out_reg.hour;
    assign m_minute  = out_reg.minute;
    assign m_second  = out_reg.second;
    assign m_weekday = out_reg.weekday;

endmodule
